[rtl/core/firfc_pkg.sv]
// shared types and constants for the digit-serial fir filter core
package firfc_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int IDX_W      = 6;
    localparam int TAP_CNT_W  = 6;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = SAMPLE_W / DIGIT_W;
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS);
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int Q_SHIFT    = 15;

    localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RST = 6'd21;

    // item opcodes
    localparam logic OP_COEF   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // sequencer to mac control
    typedef struct packed {
        logic clear;
        logic load;
        logic step;
        logic accum;
    } mac_ctrl_t;

endpackage

[rtl/core/firfc_ifs.sv]
// valid/ready channel interfaces for commands, results and configuration
interface firfc_cmd_if
    import firfc_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [IDX_W-1:0]           coef_index;
    logic signed [COEF_W-1:0]   coef_value;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;

    modport source (output valid, op, coef_index, coef_value, sample, last, input ready);
    modport sink   (input valid, op, coef_index, coef_value, sample, last, output ready);
endinterface

interface firfc_res_if
    import firfc_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       last_out;

    modport source (output valid, filtered, last_out, input ready);
    modport sink   (input valid, filtered, last_out, output ready);
endinterface

interface firfc_cfg_if
    import firfc_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [TAP_CNT_W-1:0] tap_count;

    modport source (output valid, tap_count, input ready);
    modport sink   (input valid, tap_count, output ready);
endinterface

[rtl/core/firfc_coef_ram.sv]
// coefficient memory, one write port and one registered read port
module firfc_coef_ram
    import firfc_pkg::*;
#(
    parameter int DEPTH  = 63,
    parameter int ADDR_W = 6
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [ADDR_W-1:0]        wr_addr,
    input  logic signed [COEF_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]        rd_addr,
    output logic signed [COEF_W-1:0] rd_data
);

    logic signed [COEF_W-1:0] mem [DEPTH];
    logic signed [COEF_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/firfc_hist_buf.sv]
// sample delay line as a circular memory with per-entry valid bits
module firfc_hist_buf
    import firfc_pkg::*;
#(
    parameter int DEPTH  = 63,
    parameter int ADDR_W = 6
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic signed [SAMPLE_W-1:0] push_data,
    input  logic                       clear,
    input  logic [ADDR_W-1:0]          rd_age,
    output logic signed [SAMPLE_W-1:0] rd_data
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W:0]   DEPTH_X   = (ADDR_W + 1)'(DEPTH);

    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]           vld_reg;
    logic [ADDR_W-1:0]          head_reg;
    logic [ADDR_W-1:0]          head_next;
    logic [ADDR_W:0]            rd_sum;
    logic [ADDR_W-1:0]          rd_addr;
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic                       rd_vld_reg;

    // next write slot, wraps at the depth
    assign head_next = (head_reg == LAST_ADDR) ? '0 : head_reg + 1'b1;

    // age zero is the newest entry, older ones sit behind the head
    always_comb
    begin
        if (head_reg >= rd_age)
        begin
            rd_sum = {1'b0, head_reg} - {1'b0, rd_age};
        end
        else
        begin
            rd_sum = {1'b0, head_reg} + DEPTH_X - {1'b0, rd_age};
        end
        rd_addr = rd_sum[ADDR_W-1:0];
    end

    // head pointer and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            vld_reg  <= '0;
        end
        else if (clear)
        begin
            vld_reg <= '0;
        end
        else if (push)
        begin
            head_reg           <= head_next;
            vld_reg[head_next] <= 1'b1;
        end
    end

    // sample storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[head_next] <= push_data;
        end
    end

    // registered read with its valid bit
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        rd_vld_reg  <= vld_reg[rd_addr];
    end

    // entries never written since the last clear read as zero
    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

[rtl/core/firfc_mac.sv]
// digit-serial multiply with truncating accumulate into a wrapping 16-bit sum
module firfc_mac
    import firfc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  mac_ctrl_t                  ctrl,
    input  logic signed [COEF_W-1:0]   coef,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       last_digit,
    output logic signed [SAMPLE_W-1:0] acc
);

    logic signed [COEF_W-1:0]   c_reg;
    logic [SAMPLE_W-1:0]        s_sh_reg;
    logic [DIG_CNT_W-1:0]       dig_reg;
    logic signed [PROD_W-1:0]   p_reg;
    logic signed [PROD_W-1:0]   p_next;
    logic signed [SAMPLE_W-1:0] acc_reg;
    logic [DIGIT_W-1:0]         nib;
    logic signed [DIGIT_W:0]    digit;
    logic signed [COEF_W+DIGIT_W:0] partial;
    logic [4:0]                 shift_amt;
    logic signed [PROD_W-1:0]   p_hi;
    logic                       rnd;
    logic [SAMPLE_W-1:0]        q;

    assign last_digit = (dig_reg == DIG_CNT_W'(NUM_DIGITS - 1));

    // current digit, the top one carries the sample sign
    assign nib   = s_sh_reg[DIGIT_W-1:0];
    assign digit = last_digit ? {nib[DIGIT_W-1], nib} : {1'b0, nib};

    // one coefficient-by-digit partial product, weighted by digit position
    always_comb
    begin
        partial   = c_reg * digit;
        shift_amt = 5'(int'(dig_reg) * DIGIT_W);
        p_next    = p_reg + (PROD_W'(partial) <<< shift_amt);
    end

    // product scaled by 2^-15, truncated toward zero
    always_comb
    begin
        p_hi = p_reg >>> Q_SHIFT;
        rnd  = p_reg[PROD_W-1] && (p_reg[Q_SHIFT-1:0] != '0);
        q    = p_hi[SAMPLE_W-1:0] + SAMPLE_W'(rnd);
    end

    // operand and product registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dig_reg <= '0;
        end
        else if (ctrl.load)
        begin
            dig_reg <= '0;
        end
        else if (ctrl.step)
        begin
            dig_reg <= dig_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            c_reg    <= coef;
            s_sh_reg <= sample;
            p_reg    <= '0;
        end
        else if (ctrl.step)
        begin
            s_sh_reg <= s_sh_reg >> DIGIT_W;
            p_reg    <= p_next;
        end
    end

    // running sum, wraps modulo 2^16
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.accum)
        begin
            acc_reg <= acc_reg + q;
        end
    end

    assign acc = acc_reg;

endmodule

[rtl/core/fir_filter_full_convolution_core.sv]
// fir filter core: sequencer, delay line, coefficient memory and digit-serial mac
// a new command beat is taken only in idle, so a sample waits until the last one's result,
// and every tail result after a last beat, has been passed to the output register
// each tap steps through a memory read, an operand load, a multiply over 4-bit digits and an accumulate
// coefficient loads are written while the sequencer stays idle and give no result
// reset clears control, the delay line valid bits and tap_count (to 21); coefficients undefined
module fir_filter_full_convolution_core
    import firfc_pkg::*;
#(
    parameter int MAX_TAPS = 63
)
(
    input  logic        clk,
    input  logic        rst_n,
    firfc_cmd_if.sink   cmd,
    firfc_res_if.source res,
    firfc_cfg_if.sink   cfg
);

    localparam int ADDR_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam logic [TAP_CNT_W-1:0] TAPS_MAX = TAP_CNT_W'(MAX_TAPS);
    localparam logic [IDX_W:0]       IDX_LIMIT = (IDX_W + 1)'(MAX_TAPS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PUSH = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_LOAD = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_ACC  = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0]                 state_reg, state_next;
    logic [TAP_CNT_W-1:0]       tap_reg, tap_next;
    logic [TAP_CNT_W-1:0]       n_reg, n_next;
    logic [TAP_CNT_W-1:0]       tail_reg, tail_next;
    logic                       last_reg, last_next;
    logic signed [SAMPLE_W-1:0] push_val_reg, push_val_next;
    logic [TAP_CNT_W-1:0]       tap_count_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] filtered_reg;
    logic                       last_out_reg;

    logic                       cmd_fire;
    logic                       out_free;
    logic                       emit_fire;
    logic                       rec_end;
    logic [TAP_CNT_W-1:0]       n_cur;
    logic                       coef_wr;
    logic signed [COEF_W-1:0]   coef_rd;
    logic signed [SAMPLE_W-1:0] hist_rd;
    logic                       mac_last_digit;
    logic signed [SAMPLE_W-1:0] mac_acc;
    mac_ctrl_t                  mac_ctrl;

    // handshakes
    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;
    assign out_free  = !out_valid_reg || res.ready;
    assign emit_fire = (state_reg == S_EMIT) && out_free;
    assign rec_end   = last_reg && (tail_reg == '0);

    // taps in use, saturated to the table size
    assign n_cur = (tap_count_reg > TAPS_MAX) ? TAPS_MAX : tap_count_reg;

    // coefficient load of an in-range tap
    assign coef_wr = cmd_fire && (cmd.op == OP_COEF) && ({1'b0, cmd.coef_index} < IDX_LIMIT);

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAP_COUNT_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            tap_count_reg <= cfg.tap_count;
        end
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        tap_next      = tap_reg;
        n_next        = n_reg;
        tail_next     = tail_reg;
        last_next     = last_reg;
        push_val_next = push_val_reg;
        mac_ctrl      = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire && (cmd.op == OP_SAMPLE))
                begin
                    push_val_next = cmd.sample;
                    last_next     = cmd.last;
                    n_next        = n_cur;
                    tail_next     = (cmd.last && (n_cur != '0)) ? n_cur - 1'b1 : '0;
                    state_next    = S_PUSH;
                end
            end
            S_PUSH:
            begin
                mac_ctrl.clear = 1'b1;
                tap_next       = '0;
                state_next     = (n_reg == '0) ? S_EMIT : S_READ;
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                mac_ctrl.load = 1'b1;
                state_next    = S_MUL;
            end
            S_MUL:
            begin
                mac_ctrl.step = 1'b1;
                if (mac_last_digit)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                mac_ctrl.accum = 1'b1;
                if (TAP_CNT_W'(tap_reg + 1'b1) == n_reg)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    tap_next   = tap_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    if (tail_reg != '0)
                    begin
                        tail_next     = tail_reg - 1'b1;
                        push_val_next = '0;
                        state_next    = S_PUSH;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tap_reg   <= '0;
            n_reg     <= '0;
            tail_reg  <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
            n_reg     <= n_next;
            tail_reg  <= tail_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        push_val_reg <= push_val_next;
    end

    // output register, frees the sequencer from the result side
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            filtered_reg <= mac_acc;
            last_out_reg <= rec_end;
        end
    end

    assign res.valid    = out_valid_reg;
    assign res.filtered = filtered_reg;
    assign res.last_out = last_out_reg;

    // coefficient table
    firfc_coef_ram #(
        .DEPTH  (MAX_TAPS),
        .ADDR_W (ADDR_W)
    ) u_coef_ram (
        .clk     (clk),
        .wr_en   (coef_wr),
        .wr_addr (cmd.coef_index[ADDR_W-1:0]),
        .wr_data (cmd.coef_value),
        .rd_addr (tap_reg[ADDR_W-1:0]),
        .rd_data (coef_rd)
    );

    // delay line, cleared at the end of each record
    firfc_hist_buf #(
        .DEPTH  (MAX_TAPS),
        .ADDR_W (ADDR_W)
    ) u_hist_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (state_reg == S_PUSH),
        .push_data (push_val_reg),
        .clear     (emit_fire && rec_end),
        .rd_age    (tap_reg[ADDR_W-1:0]),
        .rd_data   (hist_rd)
    );

    // shared multiply-accumulate
    firfc_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (mac_ctrl),
        .coef       (coef_rd),
        .sample     (hist_rd),
        .last_digit (mac_last_digit),
        .acc        (mac_acc)
    );

`ifndef ASSERT_OFF
    // a new result only comes out of the emit state
    a_res_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg || res.ready) && $past(1'b1) && out_valid_reg && !$past(out_valid_reg)
        |-> $past(state_reg) == S_EMIT)
        else $error("result raised outside emit state");

    // tap walk stays below the taps in use
    a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (tap_reg < n_reg))
        else $error("tap index beyond taps in use");

    // remaining tail count stays below the tap count, or is zero
    a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (tail_reg < n_reg) || (tail_reg == '0))
        else $error("tail count out of range");

    // a flagged final result ends the record
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire && rec_end |=> (state_reg == S_IDLE) && last_out_reg)
        else $error("final result did not end the record");
`endif

endmodule
